// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on i_clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- design/ffpa_pkg.sv -----
// ----------------------------------------------------------------------------
// ffpa_pkg
// Constants, state type and controller/datapath bundles of the page allocator
// ----------------------------------------------------------------------------
package ffpa_pkg;

    // map geometry
    localparam int PAGES      = 32;
    localparam int OWNER_BITS = 8;
    localparam int PAGE_W     = $clog2(PAGES);
    localparam int IDX_W      = $clog2(PAGES + 1);

    // field widths
    localparam int OWNER_W = 8;
    localparam int CNT_W   = 6;
    localparam int START_W = 5;
    localparam int END_W   = CNT_W + 1;

    // register reset value
    localparam logic [CNT_W-1:0] PAGES_IN_USE_RST = CNT_W'(PAGES);

    // operation codes
    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MARK,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        logic mark;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic scan_done;
        logic found;
        logic out_free;
    } t_dp_stat;

endpackage

// ----- design/ffpa_req_if.sv -----
// ----------------------------------------------------------------------------
// ffpa_req_if
// Request channel: operation, owner and page count with valid/ready
// ----------------------------------------------------------------------------
interface ffpa_req_if import ffpa_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               operation;
    logic [OWNER_W-1:0] owner_id;
    logic [CNT_W-1:0]   page_count;

    modport source (output valid, operation, owner_id, page_count, input ready);
    modport sink   (input valid, operation, owner_id, page_count, output ready);
endinterface

// ----- design/ffpa_rsp_if.sv -----
// ----------------------------------------------------------------------------
// ffpa_rsp_if
// Response channel: success flag and start page with valid/ready
// ----------------------------------------------------------------------------
interface ffpa_rsp_if import ffpa_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               success;
    logic [START_W-1:0] start_page;

    modport source (output valid, success, start_page, input ready);
    modport sink   (input valid, success, start_page, output ready);
endinterface

// ----- design/ffpa_cfg_if.sv -----
// ----------------------------------------------------------------------------
// ffpa_cfg_if
// Configuration write channel for the pages_in_use register
// ----------------------------------------------------------------------------
interface ffpa_cfg_if import ffpa_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ----- design/ffpa_ctrl.sv -----
// ----------------------------------------------------------------------------
// ffpa_ctrl
// Sequencer: accepts a request, walks the map, marks a run, posts the result
// ----------------------------------------------------------------------------
module ffpa_ctrl import ffpa_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_req_valid,
    output logic     o_req_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_stat.scan_done) begin
                    n_state = i_stat.found ? ST_MARK : ST_DONE;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            ST_MARK: begin
                o_cmd.mark = 1'b1;
                n_state    = ST_DONE;
            end
            ST_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- design/ffpa_datapath.sv -----
// ----------------------------------------------------------------------------
// ffpa_datapath
// Ownership map, scan counters, run tracking, config and output registers
// ----------------------------------------------------------------------------
module ffpa_datapath import ffpa_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    output t_dp_stat           o_stat,
    input  logic               i_op,
    input  logic [OWNER_W-1:0] i_owner,
    input  logic [CNT_W-1:0]   i_count,
    input  logic               i_cfg_valid,
    input  logic [CNT_W-1:0]   i_cfg_data,
    output logic               o_cfg_ready,
    input  logic               i_rsp_ready,
    output logic               o_rsp_valid,
    output logic               o_success,
    output logic [START_W-1:0] o_start_page
);

    logic [CNT_W-1:0]      r_pages_in_use;
    logic [OWNER_BITS-1:0] r_map [PAGES];
    logic                  r_op;
    logic [OWNER_BITS-1:0] r_owner;
    logic [CNT_W-1:0]      r_count;
    logic [IDX_W-1:0]      r_idx;
    logic [CNT_W-1:0]      r_run;
    logic [PAGE_W-1:0]     r_begin;
    logic                  r_found;
    logic                  r_rsp_valid;
    logic                  r_success;
    logic [START_W-1:0]    r_start;

    logic [IDX_W-1:0]      w_limit;
    logic [OWNER_BITS-1:0] w_entry;
    logic                  w_free;
    logic [CNT_W-1:0]      w_run_inc;
    logic [END_W-1:0]      w_end;

    // config register, always writable
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pages_in_use <= PAGES_IN_USE_RST;
        end else if (i_cfg_valid) begin
            r_pages_in_use <= i_cfg_data;
        end
    end

    // managed page count, saturated at the map size
    assign w_limit = (r_pages_in_use > CNT_W'(PAGES)) ? IDX_W'(PAGES)
                                                       : IDX_W'(r_pages_in_use);

    // current page under the scan pointer
    assign w_entry   = r_map[r_idx[PAGE_W-1:0]];
    assign w_free    = (w_entry == '0);
    assign w_run_inc = r_run + CNT_W'(1);
    assign w_end     = END_W'(r_begin) + END_W'(r_count);

    // scan ends on a hit, at the limit, or at once for a null owner or a zero-count allocate
    assign o_stat.scan_done = r_found || (r_idx >= w_limit) || (r_owner == '0)
                              || ((r_op == OP_ALLOC) && (r_count == '0));
    assign o_stat.found     = r_found;
    assign o_stat.out_free  = !r_rsp_valid || i_rsp_ready;

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_op;
            r_owner <= i_owner[OWNER_BITS-1:0];
            r_count <= i_count;
        end
    end

    // scan pointer and free-run tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_run   <= '0;
            r_begin <= '0;
            r_found <= 1'b0;
        end else if (i_cmd.load) begin
            r_idx   <= '0;
            r_run   <= '0;
            r_begin <= '0;
            r_found <= 1'b0;
        end else if (i_cmd.step) begin
            r_idx <= r_idx + IDX_W'(1);
            if (r_op == OP_ALLOC) begin
                if (w_free) begin
                    if (r_run == '0) begin
                        r_begin <= r_idx[PAGE_W-1:0];
                    end
                    r_run <= w_run_inc;
                    if (w_run_inc == r_count) begin
                        r_found <= 1'b1;
                    end
                end else begin
                    r_run <= '0;
                end
            end
        end
    end

    // ownership map: release clears one page per step, mark fills the run at once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < PAGES; j++) begin
                r_map[j] <= '0;
            end
        end else if (i_cmd.step && (r_op == OP_RELEASE)) begin
            if (w_entry == r_owner) begin
                r_map[r_idx[PAGE_W-1:0]] <= '0;
            end
        end else if (i_cmd.mark) begin
            for (int j = 0; j < PAGES; j++) begin
                if ((END_W'(j) >= END_W'(r_begin)) && (END_W'(j) < w_end)) begin
                    r_map[j] <= r_owner;
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_rsp_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_success <= (r_op == OP_RELEASE) || r_found;
            r_start   <= ((r_op == OP_ALLOC) && r_found) ? START_W'(r_begin) : '0;
        end
    end

    assign o_rsp_valid  = r_rsp_valid;
    assign o_success    = r_success;
    assign o_start_page = r_start;

endmodule

// ----- design/first_fit_page_allocator.sv -----
// Sequence: accept, scan, mark (allocate hit only), result beat; the scan walks up to N
// pages, N being pages_in_use capped at 32, and an allocate stops on the first fitting run.
// Throughput: one request at a time, set by the single-page-per-cycle map scan;
// the next request is taken while the previous result beat still waits.
// Reset: synchronous active low; clears the map to free at once, pages_in_use to 32.
// ----------------------------------------------------------------------------
// first_fit_page_allocator
// First-fit contiguous page allocator with per-owner release
// ----------------------------------------------------------------------------
module first_fit_page_allocator import ffpa_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ffpa_req_if.sink    i_req,
    ffpa_rsp_if.source  o_rsp,
    ffpa_cfg_if.sink    i_cfg
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // sequencer
    ffpa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // map and result datapath
    ffpa_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_op         (i_req.operation),
        .i_owner      (i_req.owner_id),
        .i_count      (i_req.page_count),
        .i_cfg_valid  (i_cfg.valid),
        .i_cfg_data   (i_cfg.data),
        .o_cfg_ready  (i_cfg.ready),
        .i_rsp_ready  (o_rsp.ready),
        .o_rsp_valid  (o_rsp.valid),
        .o_success    (o_rsp.success),
        .o_start_page (o_rsp.start_page)
    );

endmodule

// ----- design/ffpa_checker.sv -----
// ----------------------------------------------------------------------------
// ffpa_checker
// Port-level checks of the page allocator, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ffpa_checker import ffpa_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_req_valid,
    input logic               i_req_ready,
    input logic               i_rsp_valid,
    input logic               i_rsp_ready,
    input logic               i_success,
    input logic [START_W-1:0] i_start_page
);

    // one request in flight: no new beat right after an accept
    `ASSERT_NEXT(a_one_in_flight, i_req_valid && i_req_ready, !i_req_ready)

    // a failed allocate reports start page zero
    `ASSERT_IMPLIES(a_fail_start_zero, i_rsp_valid && !i_success, i_start_page == '0)

    // a stalled result beat holds
    `ASSERT_NEXT(a_rsp_hold, i_rsp_valid && !i_rsp_ready,
                 i_rsp_valid && $stable(i_success) && $stable(i_start_page))

endmodule

bind first_fit_page_allocator ffpa_checker u_ffpa_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_success    (o_rsp.success),
    .i_start_page (o_rsp.start_page)
);

// ----- sim/first_fit_page_allocator_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// first_fit_page_allocator_tb
// Drives allocate and release requests plus pages_in_use writes into the
// page allocator, keeps its own copy of the ownership map to predict each
// result beat, and checks every beat field by field in order of arrival.
// ----------------------------------------------------------------------------
module first_fit_page_allocator_tb;
    import ffpa_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 8;
    localparam int MAX_GAP      = 7;
    localparam int HOLD_CYCLES  = 4;
    localparam int TAIL_CYCLES  = PAGES + 8;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int RANDOM_ITEMS = 450;
    localparam int PHASES       = 9;

    typedef enum logic [1:0] {
        STEP_REQ,
        STEP_CFG,
        STEP_HOLD
    } t_step_kind;

    typedef struct {
        t_step_kind         kind;
        logic               op;
        logic [OWNER_W-1:0] owner;
        logic [CNT_W-1:0]   count;
        logic [CNT_W-1:0]   value;
    } t_plan_step;

    typedef struct packed {
        logic               success;
        logic [START_W-1:0] start_page;
    } t_grant;

    logic i_clk;
    logic i_rst_n;
    int   cycle_count = 0;
    int   error_count = 0;
    int   send_wait   = 0;
    int   recv_wait   = 0;
    int   hold_count  = 0;

    t_plan_step request_plan[$];
    t_grant     expected_grants[$];

    // predicted map and register
    logic [OWNER_BITS-1:0] owner_map [PAGES];
    logic [CNT_W-1:0]      pages_managed;

    ffpa_req_if req_bus();
    ffpa_rsp_if rsp_bus();
    ffpa_cfg_if cfg_bus();

    first_fit_page_allocator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus),
        .i_cfg   (cfg_bus)
    );

    // clock and the single reset
    initial begin
        i_clk   = 1'b0;
        i_rst_n = 1'b0;
        fork
            forever #CLK_HALF i_clk = ~i_clk;
            begin
                repeat (RESET_CYCLES) @(posedge i_clk);
                i_rst_n <= 1'b1;
            end
        join_none
    end

    // known values on every input from time zero, model reset state
    initial begin
        req_bus.valid      = 1'b0;
        req_bus.operation  = OP_ALLOC;
        req_bus.owner_id   = '0;
        req_bus.page_count = '0;
        cfg_bus.valid      = 1'b0;
        cfg_bus.data       = '0;
        rsp_bus.ready      = 1'b0;
        pages_managed      = PAGES_IN_USE_RST;
        for (int p = 0; p < PAGES; p++) owner_map[p] = '0;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    // watchdog
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    // per-item wait, with calm stretches where neither side idles
    function automatic int draw_wait();
        if (((cycle_count / 1500) % 4) == 3) return 0;
        return $urandom_range(0, MAX_GAP);
    endfunction

    // first fit allocate or per-owner release on the predicted map
    function automatic t_grant allocate_or_release(logic op, logic [OWNER_W-1:0] owner,
                                                   logic [CNT_W-1:0] count);
        int                    limit;
        int                    run;
        int                    first;
        bit                    hit;
        logic [OWNER_BITS-1:0] tag;
        t_grant                res;
        limit = (int'(pages_managed) > PAGES) ? PAGES : int'(pages_managed);
        tag   = owner[OWNER_BITS-1:0];
        res   = '0;
        run   = 0;
        first = 0;
        hit   = 1'b0;
        if (op == OP_ALLOC) begin
            // owner zero marks a free page, so it can never be granted
            if (tag != '0 && count != '0) begin
                for (int p = 0; p < limit && !hit; p++) begin
                    if (owner_map[p] == '0) begin
                        if (run == 0) first = p;
                        run++;
                        if (run == int'(count)) hit = 1'b1;
                    end else begin
                        run = 0;
                    end
                end
            end
            if (hit) begin
                for (int p = first; p < first + int'(count) && p < PAGES; p++)
                    owner_map[p] = tag;
                res.success    = 1'b1;
                res.start_page = START_W'(first);
            end
        end else begin
            if (tag != '0) begin
                for (int p = 0; p < limit; p++)
                    if (owner_map[p] == tag) owner_map[p] = '0;
            end
            res.success = 1'b1;
        end
        return res;
    endfunction

    task automatic plan_request(logic op, int owner, int count);
        t_plan_step s;
        s.kind  = STEP_REQ;
        s.op    = op;
        s.owner = OWNER_W'(owner);
        s.count = CNT_W'(count);
        s.value = '0;
        request_plan.push_back(s);
    endtask

    // sender stops until every expected beat is back
    task automatic plan_hold();
        t_plan_step s;
        s.kind  = STEP_HOLD;
        s.op    = OP_ALLOC;
        s.owner = '0;
        s.count = '0;
        s.value = '0;
        request_plan.push_back(s);
    endtask

    task automatic plan_setting(int value);
        t_plan_step s;
        plan_hold();
        s.kind  = STEP_CFG;
        s.op    = OP_ALLOC;
        s.owner = '0;
        s.count = '0;
        s.value = CNT_W'(value);
        request_plan.push_back(s);
    endtask

    // stimulus plan and end of run
    initial begin : stimulus
        int   pick;
        int   owner;
        int   count;
        int   setting;
        logic op;

        // directed: full-map grants, zero count, owner zero, no fit, holes
        plan_setting(32);
        plan_request(OP_ALLOC, 1, 0);
        plan_request(OP_ALLOC, 0, 4);
        plan_request(OP_ALLOC, 255, 32);
        plan_request(OP_ALLOC, 2, 1);
        plan_request(OP_RELEASE, 255, 0);
        plan_request(OP_ALLOC, 3, 63);
        plan_request(OP_ALLOC, 1, 5);
        plan_request(OP_ALLOC, 2, 3);
        plan_request(OP_ALLOC, 3, 4);
        plan_request(OP_RELEASE, 2, 63);
        plan_request(OP_ALLOC, 4, 2);
        plan_request(OP_ALLOC, 5, 4);
        plan_request(OP_RELEASE, 0, 0);
        plan_request(OP_RELEASE, 170, 17);
        plan_request(OP_ALLOC, 85, 1);
        plan_request(OP_ALLOC, 128, 20);
        // managed count zero: nothing is scanned
        plan_setting(0);
        plan_request(OP_ALLOC, 1, 1);
        plan_request(OP_RELEASE, 1, 0);
        // managed count above the map saturates
        plan_setting(63);
        plan_request(OP_RELEASE, 1, 0);
        plan_request(OP_RELEASE, 3, 0);
        plan_request(OP_ALLOC, 6, 16);
        // single managed page
        plan_setting(1);
        plan_request(OP_RELEASE, 4, 0);
        plan_request(OP_ALLOC, 7, 1);
        plan_request(OP_ALLOC, 8, 1);

        // random phases, each under its own page count
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0:       setting = 32;
                1:       setting = 63;
                2:       setting = 1;
                3:       setting = 0;
                4:       setting = 12;
                7:       setting = 32;
                default: setting = $urandom_range(2, 63);
            endcase
            plan_setting(setting);
            for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
                if (n == 25 && (ph % 2) == 0) plan_hold();
                op = ($urandom_range(0, 99) < 35) ? OP_RELEASE : OP_ALLOC;
                // mostly a small pool of owners so releases hit live runs
                if ($urandom_range(0, 99) < 85) owner = $urandom_range(1, 7);
                else owner = $urandom_range(0, 255);
                pick = $urandom_range(0, 99);
                if (pick < 70) count = $urandom_range(1, 6);
                else if (pick < 90) count = $urandom_range(0, 32);
                else count = $urandom_range(0, 63);
                plan_request(op, owner, count);
            end
        end

        while (request_plan.size() != 0 || req_bus.valid || cfg_bus.valid)
            @(negedge i_clk);
        while (expected_grants.size() != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // request and register write driver
    always @(posedge i_clk) begin : sender
        logic       req_live;
        logic       cfg_live;
        t_plan_step step;
        if (!i_rst_n) begin
            req_bus.valid <= 1'b0;
            cfg_bus.valid <= 1'b0;
            send_wait     <= 0;
            hold_count    <= 0;
        end else begin
            req_live = req_bus.valid && !req_bus.ready;
            cfg_live = cfg_bus.valid && !cfg_bus.ready;
            if (!req_live && !cfg_live) begin
                if (send_wait > 0) begin
                    send_wait <= send_wait - 1;
                end else if (request_plan.size() != 0) begin
                    step = request_plan[0];
                    case (step.kind)
                        STEP_REQ: begin
                            void'(request_plan.pop_front());
                            req_bus.operation  <= step.op;
                            req_bus.owner_id   <= step.owner;
                            req_bus.page_count <= step.count;
                            req_live = 1'b1;
                            send_wait <= draw_wait();
                        end
                        STEP_CFG: begin
                            void'(request_plan.pop_front());
                            cfg_bus.data <= step.value;
                            cfg_live = 1'b1;
                            send_wait <= draw_wait();
                        end
                        default: begin
                            // idle only once nothing is in flight this edge
                            if (!req_bus.valid && !(rsp_bus.valid && rsp_bus.ready)
                                    && expected_grants.size() == 0) begin
                                if (hold_count >= HOLD_CYCLES - 1) begin
                                    void'(request_plan.pop_front());
                                    hold_count <= 0;
                                end else begin
                                    hold_count <= hold_count + 1;
                                end
                            end else begin
                                hold_count <= 0;
                            end
                        end
                    endcase
                end
            end
            req_bus.valid <= req_live;
            cfg_bus.valid <= cfg_live;
        end
    end

    // result receiver with per-beat stalls
    always @(posedge i_clk) begin : receiver
        int next_wait;
        if (!i_rst_n) begin
            rsp_bus.ready <= 1'b0;
            recv_wait     <= 0;
        end else if (rsp_bus.valid && rsp_bus.ready) begin
            next_wait = draw_wait();
            recv_wait     <= next_wait;
            rsp_bus.ready <= (next_wait == 0);
        end else if (recv_wait > 0) begin
            recv_wait     <= recv_wait - 1;
            rsp_bus.ready <= (recv_wait == 1);
        end else begin
            rsp_bus.ready <= 1'b1;
        end
    end

    // check result beats, then track register writes and accepted requests
    always @(posedge i_clk) begin : scoreboard
        t_grant want;
        if (i_rst_n) begin
            if (rsp_bus.valid && rsp_bus.ready) begin
                if (expected_grants.size() == 0) begin
                    $error("result beat with no request outstanding");
                    error_count++;
                end else begin
                    want = expected_grants.pop_front();
                    if (rsp_bus.success !== want.success) begin
                        $error("success: expected %0d, actual %0d",
                               want.success, rsp_bus.success);
                        error_count++;
                    end
                    if (rsp_bus.start_page !== want.start_page) begin
                        $error("start_page: expected %0d, actual %0d",
                               want.start_page, rsp_bus.start_page);
                        error_count++;
                    end
                end
            end
            if (cfg_bus.valid && cfg_bus.ready) pages_managed = cfg_bus.data;
            if (req_bus.valid && req_bus.ready)
                expected_grants.push_back(allocate_or_release(req_bus.operation,
                                                              req_bus.owner_id,
                                                              req_bus.page_count));
        end
    end

endmodule
